[rtl/core/assert_macros.svh]
// assertion macros used by the checker file shs_checker.sv
// clocked on aclk, disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shs checker: same-cycle implication failed");

// next-cycle implication
`define SHS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shs checker: next-cycle implication failed");

`endif

[rtl/core/shs_pkg.sv]
// shared types and constants of the sha-256 stream hasher
// no dependencies
package shs_pkg;

    typedef logic [31:0] word_t;

    localparam logic [0:7][31:0] SHS_H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] SHS_PAD_BYTE = 8'h80;
    localparam logic [5:0] SHS_LEN_POS  = 6'd56;
    localparam logic [5:0] SHS_LEN_LOW  = 6'd60;
    localparam logic [5:0] SHS_LAST_RND = 6'd63;
    localparam logic [2:0] SHS_LAST_IDX = 3'd7;
    localparam word_t      SHS_BLK_BITS = 32'd512;

    typedef struct packed {
        logic       shift_byte;
        logic       pad_byte;
        logic       start_pad;
        logic       load_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update;
        logic       add_block;
        logic       restart;
        logic [2:0] word_idx;
    } shs_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic fin_block;
    } shs_sts_t;

    function automatic word_t shs_round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

[rtl/core/shs_datapath.sv]
// datapath: block buffer, padding, compression round and hash words
// depends on shs_pkg; driven by shs_ctrl through shs_cmd_t
module shs_datapath import shs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  shs_cmd_t cmd,
    input  logic [7:0] data_byte,
    output shs_sts_t sts,
    output word_t    digest_word
);

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [511:0] line_reg, line_next;
    word_t        h_reg [8];
    word_t        h_next [8];
    word_t        v_reg [8];
    word_t        v_next [8];
    logic [5:0]   cnt_reg, cnt_next;
    word_t        bits_reg, bits_next;
    word_t        len_reg, len_next;
    logic         fin_block_reg, fin_block_next;
    logic         first_reg, first_next;

    logic [7:0] pad_val;
    logic [7:0] byte_in;
    word_t      w0, w1, w9, w14, w_new;
    word_t      t1, t2, ch, maj;

    assign w0  = line_reg[511:480];
    assign w1  = line_reg[479:448];
    assign w9  = line_reg[223:192];
    assign w14 = line_reg[63:32];

    assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
               + ch + shs_round_k(cmd.round_idx) + w0;
    assign t2  = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22)) + maj;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    pad_val = len_reg[31:24];
            2'd1:    pad_val = len_reg[23:16];
            2'd2:    pad_val = len_reg[15:8];
            default: pad_val = len_reg[7:0];
        endcase
        if (first_reg) begin
            pad_val = SHS_PAD_BYTE;
        end else if (!(fin_block_reg && cnt_reg >= SHS_LEN_LOW)) begin
            pad_val = 8'h00;
        end
    end

    assign byte_in = cmd.pad_byte ? pad_val : data_byte;

    always_comb begin
        line_next      = line_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        fin_block_next = fin_block_reg;
        first_next     = first_reg;
        for (int i = 0; i < 8; i++) begin
            h_next[i] = h_reg[i];
            v_next[i] = v_reg[i];
        end

        if (cmd.shift_byte) begin
            line_next = {line_reg[503:0], byte_in};
            cnt_next  = cnt_reg + 6'd1;
            if (cmd.pad_byte) begin
                first_next = 1'b0;
            end
        end
        if (cmd.start_pad) begin
            len_next       = bits_reg + {23'd0, cnt_reg, 3'd0};
            fin_block_next = cnt_reg < SHS_LEN_POS;
            first_next     = 1'b1;
        end
        if (cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                v_next[i] = h_reg[i];
            end
        end
        if (cmd.round_en) begin
            line_next = {line_reg[479:0], w_new};
            for (int i = 1; i < 8; i++) begin
                v_next[i] = v_reg[i - 1];
            end
            v_next[4] = v_reg[3] + t1;
            v_next[0] = t1 + t2;
        end
        if (cmd.update) begin
            for (int i = 0; i < 8; i++) begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
            if (cmd.add_block) begin
                bits_next = bits_reg + SHS_BLK_BITS;
            end else begin
                fin_block_next = 1'b1;
            end
        end
        if (cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                h_next[i] = SHS_H_INIT[i];
            end
            cnt_next  = 6'd0;
            bits_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= SHS_H_INIT[i];
            end
            cnt_reg       <= 6'd0;
            bits_reg      <= 32'd0;
            fin_block_reg <= 1'b0;
            first_reg     <= 1'b0;
        end else begin
            h_reg         <= h_next;
            cnt_reg       <= cnt_next;
            bits_reg      <= bits_next;
            fin_block_reg <= fin_block_next;
            first_reg     <= first_next;
        end
        line_reg <= line_next;
        v_reg    <= v_next;
        len_reg  <= len_next;
    end

    assign sts.cnt_last  = cnt_reg == SHS_LAST_RND;
    assign sts.fin_block = fin_block_reg;
    assign digest_word   = h_reg[cmd.word_idx];

endmodule

[rtl/core/shs_ctrl.sv]
// controller: sequences byte intake, padding, rounds and digest output
// depends on shs_pkg; commands shs_datapath through shs_cmd_t
module shs_ctrl import shs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     has_byte,
    input  logic     end_of_msg,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output logic     m_tlast,
    output logic [2:0] word_index,
    input  shs_sts_t sts,
    output shs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_INIT,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_pend_reg, fin_pend_next;
    logic       pad_mode_reg, pad_mode_next;
    logic       tready_reg;
    logic       tvalid_reg;
    logic       s_acc, m_acc;

    assign s_acc = s_tvalid && tready_reg;
    assign m_acc = tvalid_reg && m_tready;

    always_comb begin
        state_next    = state_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        fin_pend_next = fin_pend_reg;
        pad_mode_next = pad_mode_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        cmd.word_idx  = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd.shift_byte = has_byte;
                    if (has_byte && sts.cnt_last) begin
                        cmd.load_work = 1'b1;
                        fin_pend_next = end_of_msg;
                        round_next    = 6'd0;
                        state_next    = ST_ROUND;
                    end else if (end_of_msg) begin
                        state_next = ST_PAD_INIT;
                    end
                end
            end
            ST_PAD_INIT: begin
                cmd.start_pad = 1'b1;
                pad_mode_next = 1'b1;
                state_next    = ST_PAD;
            end
            ST_PAD: begin
                cmd.shift_byte = 1'b1;
                cmd.pad_byte   = 1'b1;
                if (sts.cnt_last) begin
                    cmd.load_work = 1'b1;
                    round_next    = 6'd0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == SHS_LAST_RND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update    = 1'b1;
                cmd.add_block = !pad_mode_reg;
                if (pad_mode_reg) begin
                    if (sts.fin_block) begin
                        idx_next   = 3'd0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PAD;
                    end
                end else if (fin_pend_reg) begin
                    state_next = ST_PAD_INIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (idx_reg == SHS_LAST_IDX) begin
                        cmd.restart   = 1'b1;
                        pad_mode_next = 1'b0;
                        fin_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= 6'd0;
            idx_reg      <= 3'd0;
            fin_pend_reg <= 1'b0;
            pad_mode_reg <= 1'b0;
            tready_reg   <= 1'b0;
            tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
            fin_pend_reg <= fin_pend_next;
            pad_mode_reg <= pad_mode_next;
            tready_reg   <= state_next == ST_IDLE;
            tvalid_reg   <= state_next == ST_OUT;
        end
    end

    assign s_tready   = tready_reg;
    assign m_tvalid   = tvalid_reg;
    assign m_tlast    = idx_reg == SHS_LAST_IDX;
    assign word_index = idx_reg;

endmodule

[rtl/core/sha256_stream_hasher_top.sv]
// sha-256 stream hasher: one byte per beat in, eight digest words out
// a non-final byte of a block is shifted in; the final one also starts 64 rounds + 1 update
// end of message: a setup state, then pad bytes shift in and each padded block is hashed
// then eight output beats; the core computes one round per cycle and takes no byte meanwhile
// aresetn is synchronous: hash words take their initial values, counters clear
module sha256_stream_hasher_top import shs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // last_word
);

    shs_cmd_t   cmd;
    shs_sts_t   sts;
    word_t      digest_word;
    logic [2:0] word_index;

    shs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .has_byte   (s_tuser[0]),
        .end_of_msg (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .word_index (word_index),
        .sts        (sts),
        .cmd        (cmd)
    );

    shs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .sts         (sts),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'd0, word_index, digest_word};

endmodule

[rtl/core/shs_checker.sv]
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module shs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    logic [2:0] out_idx;
    logic       out_acc;

    assign out_idx = m_tdata[34:32];
    assign out_acc = m_tvalid && m_tready;

    `SHS_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
    `SHS_ASSERT_IMP(a_last_idx, m_tvalid, m_tlast == (out_idx == 3'd7))
    `SHS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SHS_ASSERT_NXT(a_step, out_acc && !m_tlast, m_tvalid && (out_idx == $past(out_idx) + 3'd1))
    `SHS_ASSERT_NXT(a_done, out_acc && m_tlast, s_tready && !m_tvalid)

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
